### sv/thdt_pkg.sv
// Shared types and constants for the thermistor divider to temperature block.
// No dependencies; every other file imports this package.
package thdt_pkg;

   localparam int VOLT_W  = 16;
   localparam int FIX_W   = 20;
   localparam int CNT_W   = 6;
   localparam int RES_W   = 32;
   localparam int TEMP_W  = 9;
   localparam int OUT_T_W = 17;
   localparam int STAT_W  = 2;

   // Divider shift register width and step counts
   localparam int QW = 52;
   localparam int DW = 33;
   localparam logic [5:0] DIV1_STEPS = 6'd40;
   localparam logic [5:0] DIV2_STEPS = 6'd52;

   localparam logic [1:0] REG_SUPPLY  = 2'd0;
   localparam logic [1:0] REG_FIXED   = 2'd1;
   localparam logic [1:0] REG_ENTRIES = 2'd2;

   localparam logic [STAT_W-1:0] STAT_IN_RANGE = 2'd0;
   localparam logic [STAT_W-1:0] STAT_TOO_HOT  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_TOO_COLD = 2'd2;

   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_CONVERT = 1'b1;

   localparam logic PHASE_RES  = 1'b0;
   localparam logic PHASE_TEMP = 1'b1;

   typedef struct packed {
      logic                     is_load;
      logic                     load_ok;
      logic [4:0]               index;
      logic [RES_W-1:0]         res;
      logic signed [TEMP_W-1:0] temp;
      logic [VOLT_W-1:0]        volt;
   } item_type;

   typedef struct packed {
      logic [VOLT_W-1:0] supply;
      logic [FIX_W-1:0]  fixed;
      logic [CNT_W-1:0]  entries;
   } cfg_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_DIV,
      S_WALK,
      S_WALK_END,
      S_EVAL,
      S_MUL_A,
      S_MUL_B,
      S_SUM,
      S_DONE
   } state_type;

endpackage

### sv/thermistor_divider_to_temperature_core.sv
// NTC divider to temperature converter: load transactions fill the resistance/temperature
// table, convert transactions return resistance, temperature and range status. A load
// is written to the table as the idle engine pops it. A convert is clamped to the end
// entries or interpolated; it uses the one-bit-per-cycle restoring divider once for the
// resistance and once for the interpolation, and the one-entry-per-cycle table walk. A
// two-entry queue lets new transactions be taken while a conversion runs. Depends on
// thdt_pkg and submodules.
module thermistor_divider_to_temperature_core import thdt_pkg::*; #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_command,
   input  logic [4:0]                req_entry_index,
   input  logic [RES_W-1:0]          req_entry_resistance,
   input  logic signed [TEMP_W-1:0]  req_entry_temperature,
   input  logic [VOLT_W-1:0]         req_divider_voltage,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [OUT_T_W-1:0] rsp_temperature,
   output logic [RES_W-1:0]          rsp_resistance,
   output logic [STAT_W-1:0]         rsp_range_status,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [3:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] ridx;
   logic       f_valid, q_full, q_valid, q_pop;
   item_type   f_item, q_item;

   assign csr_pready = 1'b1;
   assign ridx       = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (ridx)
            REG_SUPPLY:  cfg_in.supply  = csr_pwdata[VOLT_W-1:0];
            REG_FIXED:   cfg_in.fixed   = csr_pwdata[FIX_W-1:0];
            REG_ENTRIES: cfg_in.entries = csr_pwdata[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (ridx)
         REG_SUPPLY:  csr_prdata = {16'b0, cfg_ff.supply};
         REG_FIXED:   csr_prdata = {12'b0, cfg_ff.fixed};
         REG_ENTRIES: csr_prdata = {26'b0, cfg_ff.entries};
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.supply  <= 16'd3300;
         cfg_ff.fixed   <= 20'd10000;
         cfg_ff.entries <= 6'd29;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   thdt_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_command           (req_command),
      .req_entry_index       (req_entry_index),
      .req_entry_resistance  (req_entry_resistance),
      .req_entry_temperature (req_entry_temperature),
      .req_divider_voltage   (req_divider_voltage),
      .q_full                (q_full),
      .item_valid            (f_valid),
      .item                  (f_item)
   );

   thdt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_item   (f_item),
      .full      (q_full),
      .out_valid (q_valid),
      .out_item  (q_item),
      .out_pop   (q_pop)
   );

   thdt_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_temperature  (rsp_temperature),
      .rsp_resistance   (rsp_resistance),
      .rsp_range_status (rsp_range_status)
   );

endmodule

### sv/thdt_front.sv
// Front end: accepts request transactions and classifies them into queue items.
// Depends on thdt_pkg.
module thdt_front import thdt_pkg::*; #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_command,
   input  logic [4:0]               req_entry_index,
   input  logic [RES_W-1:0]         req_entry_resistance,
   input  logic signed [TEMP_W-1:0] req_entry_temperature,
   input  logic [VOLT_W-1:0]        req_divider_voltage,
   input  logic                     q_full,
   output logic                     item_valid,
   output item_type                 item
);

   logic     v_ff, v_in;
   item_type item_ff, item_in;
   logic     accept;

   assign req_stall  = v_ff & q_full;
   assign accept     = req_valid & ~req_stall;
   assign item_valid = v_ff;
   assign item       = item_ff;

   always_comb begin
      item_in.is_load = (req_command == CMD_LOAD);
      // loads beyond the table are dropped by the back end
      item_in.load_ok = ({4'b0, req_entry_index} < 9'(TABLE_DEPTH));
      item_in.index   = req_entry_index;
      item_in.res     = req_entry_resistance;
      item_in.temp    = req_entry_temperature;
      item_in.volt    = req_divider_voltage;
      if (accept) begin
         v_in = 1'b1;
      end else if (~q_full) begin
         v_in = 1'b0;
      end else begin
         v_in = v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

### sv/thdt_queue.sv
// Two-entry queue decoupling the front end from the conversion engine.
// Depends on thdt_pkg.
module thdt_queue import thdt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  item_type in_item,
   output logic     full,
   output logic     out_valid,
   output item_type out_item,
   input  logic     out_pop
);

   item_type   slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign full      = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = slot_ff[rd_ff];
   assign push      = in_valid & ~full;
   assign pop       = out_pop & out_valid;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= in_item;
      end
   end

endmodule

### sv/thdt_back.sv
// Conversion engine: table memory, resistance division, table walk,
// interpolation and a shared restoring divider. Depends on thdt_pkg.
module thdt_back import thdt_pkg::*; #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  logic                      q_valid,
   input  item_type                  q_item,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [OUT_T_W-1:0] rsp_temperature,
   output logic [RES_W-1:0]          rsp_resistance,
   output logic [STAT_W-1:0]         rsp_range_status
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int IW = (AW > 5) ? AW : 5;
   localparam int MW = RES_W + TEMP_W;

   state_type state_ff, state_in;

   logic [MW-1:0] mem [TABLE_DEPTH];
   logic [MW-1:0] mem_q_ff;
   logic [IW-1:0] widx;

   logic [VOLT_W-1:0]        volt_ff, volt_in;
   logic [RES_W-1:0]         r_ff, r_in;
   logic [QW-1:0]            q_ff, q_in;
   logic [DW-1:0]            rem_ff, rem_in, div_ff, div_in;
   logic [5:0]               cnt_ff, cnt_in;
   logic                     phase_ff, phase_in;
   logic [AW-1:0]            a_ff, a_in, rd_j_ff, rd_j_in;
   logic                     rd_v_ff, rd_v_in;
   logic [MW-1:0]            prev_ff, prev_in, e0_ff, e0_in, el_ff, el_in;
   logic [RES_W-1:0]         rhi_ff, rhi_in, rlo_ff, rlo_in;
   logic signed [TEMP_W-1:0] thi_ff, thi_in, tlo_ff, tlo_in;
   logic signed [33:0]       diff_ff, diff_in;
   logic signed [9:0]        dt_ff, dt_in;
   logic signed [42:0]       p1_ff, p1_in, p2_ff, p2_in;
   logic                     neg_ff, neg_in;
   logic [OUT_T_W-1:0]       t_ff, t_in;
   logic [STAT_W-1:0]        st_ff, st_in;
   logic                     rsp_v_ff, rsp_v_in;
   logic signed [OUT_T_W-1:0] o_t_ff, o_t_in;
   logic [RES_W-1:0]         o_r_ff, o_r_in;
   logic [STAT_W-1:0]        o_s_ff, o_s_in;

   logic [8:0]          n9;
   logic [AW-1:0]       last;
   logic                out_free, div_last, mem_we;
   logic [DW:0]         shifted;
   logic [DW+1:0]       trial;
   logic                ge;
   logic [QW-1:0]       qn;
   logic [35:0]         prod;
   logic signed [33:0]  span_s;
   logic signed [43:0]  sum;
   logic signed [QW-1:0] num;
   logic [RES_W-1:0]    cur_res, prev_res;

   // entry count clamped to 2..TABLE_DEPTH
   always_comb begin
      n9 = {3'b0, cfg.entries};
      if (n9 < 9'd2) begin
         n9 = 9'd2;
      end
      if (n9 > 9'(TABLE_DEPTH)) begin
         n9 = 9'(TABLE_DEPTH);
      end
      last = AW'(n9 - 9'd1);
   end

   assign out_free  = ~rsp_v_ff | ~rsp_stall;
   assign div_last  = (cnt_ff == 6'd1);
   assign q_pop     = (state_ff == S_IDLE);
   assign mem_we    = (state_ff == S_IDLE) & q_valid & q_item.is_load & q_item.load_ok;
   assign widx      = IW'(q_item.index);
   assign cur_res   = mem_q_ff[MW-1:TEMP_W];
   assign prev_res  = prev_ff[MW-1:TEMP_W];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[widx[AW-1:0]] <= {q_item.res, q_item.temp};
      end
      mem_q_ff <= mem[a_ff];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && !q_item.is_load) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            if (volt_ff >= cfg.supply || volt_ff == '0) begin
               state_in = S_WALK;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (div_last) begin
               state_in = (phase_ff == PHASE_RES) ? S_WALK : S_DONE;
            end
         end
         S_WALK: begin
            if (a_ff == last) begin
               state_in = S_WALK_END;
            end
         end
         S_WALK_END: state_in = S_EVAL;
         S_EVAL: begin
            if (r_ff <= el_ff[MW-1:TEMP_W] || r_ff >= e0_ff[MW-1:TEMP_W]) begin
               state_in = S_DONE;
            end else begin
               state_in = S_MUL_A;
            end
         end
         S_MUL_A: state_in = S_MUL_B;
         S_MUL_B: state_in = S_SUM;
         S_SUM:   state_in = S_DIV;
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      volt_in  = volt_ff;
      r_in     = r_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      a_in     = a_ff;
      rd_v_in  = 1'b0;
      rd_j_in  = rd_j_ff;
      prev_in  = prev_ff;
      e0_in    = e0_ff;
      el_in    = el_ff;
      rhi_in   = rhi_ff;
      rlo_in   = rlo_ff;
      thi_in   = thi_ff;
      tlo_in   = tlo_ff;
      diff_in  = diff_ff;
      dt_in    = dt_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      neg_in   = neg_ff;
      t_in     = t_ff;
      st_in    = st_ff;
      o_t_in   = o_t_ff;
      o_r_in   = o_r_ff;
      o_s_in   = o_s_ff;
      rsp_v_in = rsp_v_ff & rsp_stall;

      shifted = {rem_ff, q_ff[QW-1]};
      trial   = {1'b0, shifted} - {2'b0, div_ff};
      ge      = ~trial[DW+1];
      qn      = {q_ff[QW-2:0], ge};
      prod    = cfg.fixed * (cfg.supply - volt_ff);
      span_s  = $signed({2'b0, rhi_ff}) - $signed({2'b0, rlo_ff});
      sum     = p1_ff + p2_ff;
      num     = {sum, 8'b0};

      // table walk: data for entry rd_j_ff arrives in the cycle after its address
      if (rd_v_ff) begin
         prev_in = mem_q_ff;
         if (rd_j_ff == '0) begin
            e0_in = mem_q_ff;
         end else if (rd_j_ff == AW'(1) || (prev_res >= r_ff && cur_res < r_ff)) begin
            rhi_in = prev_res;
            rlo_in = cur_res;
            thi_in = prev_ff[TEMP_W-1:0];
            tlo_in = mem_q_ff[TEMP_W-1:0];
         end
         if (rd_j_ff == last) begin
            el_in = mem_q_ff;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            volt_in = q_item.volt;
            a_in    = '0;
         end
         S_PREP: begin
            if (volt_ff >= cfg.supply) begin
               r_in = '0;
            end else if (volt_ff == '0) begin
               r_in = '1;
            end else begin
               q_in     = {prod, 16'b0};
               rem_in   = '0;
               div_in   = {17'b0, volt_ff};
               cnt_in   = DIV1_STEPS;
               phase_in = PHASE_RES;
            end
         end
         S_DIV: begin
            rem_in = ge ? trial[DW-1:0] : shifted[DW-1:0];
            q_in   = qn;
            cnt_in = cnt_ff - 6'd1;
            if (div_last) begin
               if (phase_ff == PHASE_RES) begin
                  r_in = (qn[39:32] != '0) ? '1 : qn[31:0];
               end else begin
                  t_in  = neg_ff ? (OUT_T_W'(0) - qn[OUT_T_W-1:0]) : qn[OUT_T_W-1:0];
                  st_in = STAT_IN_RANGE;
               end
            end
         end
         S_WALK: begin
            rd_v_in = 1'b1;
            rd_j_in = a_ff;
            if (a_ff != last) begin
               a_in = a_ff + AW'(1);
            end
         end
         S_WALK_END: begin
         end
         S_EVAL: begin
            if (r_ff <= el_ff[MW-1:TEMP_W]) begin
               t_in  = {el_ff[TEMP_W-1:0], 8'b0};
               st_in = STAT_TOO_HOT;
            end else if (r_ff >= e0_ff[MW-1:TEMP_W]) begin
               t_in  = {e0_ff[TEMP_W-1:0], 8'b0};
               st_in = STAT_TOO_COLD;
            end
            div_in  = (span_s <= 34'sd0) ? DW'(1) : span_s[DW-1:0];
            diff_in = $signed({2'b0, r_ff}) - $signed({2'b0, rlo_ff});
            dt_in   = 10'(thi_ff) - 10'(tlo_ff);
         end
         S_MUL_A: begin
            p1_in = tlo_ff * $signed({1'b0, div_ff});
         end
         S_MUL_B: begin
            p2_in = diff_ff * dt_ff;
         end
         S_SUM: begin
            neg_in   = num[QW-1];
            q_in     = num[QW-1] ? (QW'(0) - num) : num;
            rem_in   = '0;
            cnt_in   = DIV2_STEPS;
            phase_in = PHASE_TEMP;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_v_in = 1'b1;
               o_t_in   = t_ff;
               o_r_in   = r_ff;
               o_s_in   = st_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_v_ff <= 1'b0;
         rd_v_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_v_ff <= rsp_v_in;
         rd_v_ff  <= rd_v_in;
      end
   end

   always_ff @(posedge clock) begin
      volt_ff  <= volt_in;
      r_ff     <= r_in;
      q_ff     <= q_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      cnt_ff   <= cnt_in;
      phase_ff <= phase_in;
      a_ff     <= a_in;
      rd_j_ff  <= rd_j_in;
      prev_ff  <= prev_in;
      e0_ff    <= e0_in;
      el_ff    <= el_in;
      rhi_ff   <= rhi_in;
      rlo_ff   <= rlo_in;
      thi_ff   <= thi_in;
      tlo_ff   <= tlo_in;
      diff_ff  <= diff_in;
      dt_ff    <= dt_in;
      p1_ff    <= p1_in;
      p2_ff    <= p2_in;
      neg_ff   <= neg_in;
      t_ff     <= t_in;
      st_ff    <= st_in;
      o_t_ff   <= o_t_in;
      o_r_ff   <= o_r_in;
      o_s_ff   <= o_s_in;
   end

   assign rsp_valid        = rsp_v_ff;
   assign rsp_temperature  = o_t_ff;
   assign rsp_resistance   = o_r_ff;
   assign rsp_range_status = o_s_ff;

endmodule
